// ===== rtl/vtd_pkg.sv =====
// Shared types, constants and decode functions for the VT escape input decoder.
package vtd_pkg;

   // Width at which every accumulated number saturates (valid range 8 to 32).
   localparam int NUMBER_WIDTH = 16;
   // Decoded-event queue between the parser and the result stage; a power of two.
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);

   typedef logic [NUMBER_WIDTH-1:0] number_type;
   typedef logic [20:0]             char_type;
   typedef logic [2:0]              mods_type;
   typedef logic [15:0]             coord_type;

   localparam number_type NUM_MAX = '1;

   typedef enum logic [1:0] {
      KIND_KEY   = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_MOUSE = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      KEY_ESC    = 4'd0,
      KEY_UP     = 4'd1,
      KEY_DOWN   = 4'd2,
      KEY_RIGHT  = 4'd3,
      KEY_LEFT   = 4'd4,
      KEY_HOME   = 4'd5,
      KEY_END    = 4'd6,
      KEY_INSERT = 4'd7,
      KEY_DELETE = 4'd8,
      KEY_PGUP   = 4'd9,
      KEY_PGDN   = 4'd10
   } key_type;

   typedef enum logic [2:0] {
      BTN_LEFT       = 3'd0,
      BTN_MIDDLE     = 3'd1,
      BTN_RIGHT      = 3'd2,
      BTN_WHEEL_UP   = 3'd3,
      BTN_WHEEL_DOWN = 3'd4
   } button_type;

   typedef enum logic [1:0] {
      ACT_DOWN   = 2'd0,
      ACT_UP     = 2'd1,
      ACT_DRAG   = 2'd2,
      ACT_SCROLL = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_GROUND = 4'b0001,
      ST_ESC    = 4'b0010,
      ST_CSI    = 4'b0100,
      ST_SS3    = 4'b1000
   } parser_state_type;

   localparam char_type CH_ESC    = 21'h1B;
   localparam char_type CH_LBRACK = 21'h5B;
   localparam char_type CH_SS3_O  = 21'h4F;
   localparam char_type CH_LESS   = 21'h3C;
   localparam char_type CH_TILDE  = 21'h7E;
   localparam char_type CH_SEMI   = 21'h3B;
   localparam char_type CH_0      = 21'h30;
   localparam char_type CH_9      = 21'h39;
   localparam char_type CH_A      = 21'h41;
   localparam char_type CH_B      = 21'h42;
   localparam char_type CH_C      = 21'h43;
   localparam char_type CH_D      = 21'h44;
   localparam char_type CH_F      = 21'h46;
   localparam char_type CH_H      = 21'h48;
   localparam char_type CH_M_UP   = 21'h4D;
   localparam char_type CH_M_LOW  = 21'h6D;

   localparam logic [31:0] MOUSE_WHEEL_UP   = 32'd64;
   localparam logic [31:0] MOUSE_WHEEL_DOWN = 32'd65;
   localparam logic [31:0] COORD_MAX        = 32'd65534;

   typedef struct packed {
      kind_type   kind;
      key_type    key;
      char_type   chr;
      mods_type   mods;
      button_type button;
      action_type action;
      coord_type  column;
      coord_type  row;
   } event_type;

   // One queue entry: an optional pending escape key followed by an optional event.
   typedef struct packed {
      logic      has_esc;
      mods_type  esc_mods;
      logic      has_event;
      event_type ev;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic    hit;
      key_type key;
   } key_hit_type;

   // v * 10 + d, saturated at the number width.
   function automatic number_type add_digit(number_type v, logic [3:0] d);
      logic [NUMBER_WIDTH+3:0] wide;
      wide = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (NUMBER_WIDTH + 4)'(d);
      return (wide > {4'b0, NUM_MAX}) ? NUM_MAX : wide[NUMBER_WIDTH-1:0];
   endfunction

   // Reported mouse coordinate to zero-based, clamped.
   function automatic coord_type to_coord(number_type v);
      logic [31:0] w;
      w = 32'(v) - 32'd1;
      if (v == '0) return '0;
      return (w > COORD_MAX) ? COORD_MAX[15:0] : w[15:0];
   endfunction

   function automatic key_hit_type letter_key(char_type ch);
      key_hit_type r;
      r.hit = 1'b1;
      r.key = KEY_ESC;
      unique case (ch)
         CH_A:    r.key = KEY_UP;
         CH_B:    r.key = KEY_DOWN;
         CH_C:    r.key = KEY_RIGHT;
         CH_D:    r.key = KEY_LEFT;
         CH_H:    r.key = KEY_HOME;
         CH_F:    r.key = KEY_END;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   function automatic key_hit_type tilde_key(number_type n);
      key_hit_type r;
      r.hit = 1'b1;
      r.key = KEY_ESC;
      unique case (32'(n)) inside
         32'd1, 32'd7: r.key = KEY_HOME;
         32'd2:        r.key = KEY_INSERT;
         32'd3:        r.key = KEY_DELETE;
         32'd4, 32'd8: r.key = KEY_END;
         32'd5:        r.key = KEY_PGUP;
         32'd6:        r.key = KEY_PGDN;
         default:      r.hit = 1'b0;
      endcase
      return r;
   endfunction

   function automatic event_type build_key_ev(key_type key, mods_type mods);
      event_type e;
      e      = '0;
      e.kind = KIND_KEY;
      e.key  = key;
      e.mods = mods;
      return e;
   endfunction

endpackage

// ===== rtl/vtd_front.sv =====
// Parser front end: accepts requests, tracks escape state and queues decoded events.
module vtd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  logic [20:0]               req_in_char,
   input  logic [2:0]                req_in_mods,
   input  vtd_pkg::queue_status_type q_status,
   output logic                      q_push,
   output vtd_pkg::entry_type        q_entry
);

   vtd_pkg::parser_state_type ps_ff, ps_in;
   logic                      sgr_ff, sgr_in;
   vtd_pkg::mods_type         esc_mods_ff, esc_mods_in;
   vtd_pkg::number_type       tilde_ff, tilde_in;
   logic                      tilde_done_ff, tilde_done_in;
   logic [1:0]                fc_ff, fc_in;
   vtd_pkg::number_type       fv_ff [3];
   vtd_pkg::number_type       fv_in [3];
   vtd_pkg::number_type       cur_ff, cur_in;

   logic                accept;
   logic                is_digit;
   logic                do_clear, do_digit, do_semi;
   vtd_pkg::event_type  char_ev, mouse_ev;
   logic                mouse_ok;
   vtd_pkg::key_hit_type letter_hit, tilde_hit;
   vtd_pkg::number_type mb, mx, my;
   logic                wheel_up, wheel_down;
   vtd_pkg::entry_type  ent;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign is_digit  = (req_in_char >= vtd_pkg::CH_0) && (req_in_char <= vtd_pkg::CH_9);

   assign letter_hit = vtd_pkg::letter_key(req_in_char);
   assign tilde_hit  = vtd_pkg::tilde_key(tilde_ff);

   always_comb begin
      char_ev      = '0;
      char_ev.kind = vtd_pkg::KIND_CHAR;
      char_ev.chr  = req_in_char;
      char_ev.mods = req_in_mods;
   end

   // The field being typed when the final arrives stands in for the next stored one.
   assign mb         = (fc_ff == 2'd0) ? cur_ff : fv_ff[0];
   assign mx         = (fc_ff == 2'd1) ? cur_ff : fv_ff[1];
   assign my         = (fc_ff == 2'd2) ? cur_ff : fv_ff[2];
   assign mouse_ok   = (fc_ff >= 2'd2);
   assign wheel_up   = (32'(mb) == vtd_pkg::MOUSE_WHEEL_UP);
   assign wheel_down = (32'(mb) == vtd_pkg::MOUSE_WHEEL_DOWN);

   always_comb begin
      mouse_ev        = '0;
      mouse_ev.kind   = vtd_pkg::KIND_MOUSE;
      mouse_ev.mods   = {mb[4], mb[3], mb[2]};
      mouse_ev.column = vtd_pkg::to_coord(mx);
      mouse_ev.row    = vtd_pkg::to_coord(my);
      if (wheel_up || wheel_down) begin
         mouse_ev.button = wheel_up ? vtd_pkg::BTN_WHEEL_UP : vtd_pkg::BTN_WHEEL_DOWN;
         mouse_ev.action = vtd_pkg::ACT_SCROLL;
      end else begin
         unique case (mb[1:0])
            2'd1:    mouse_ev.button = vtd_pkg::BTN_MIDDLE;
            2'd2:    mouse_ev.button = vtd_pkg::BTN_RIGHT;
            default: mouse_ev.button = vtd_pkg::BTN_LEFT;
         endcase
         if (mb[5]) begin
            mouse_ev.action = vtd_pkg::ACT_DRAG;
         end else if ((req_in_char == vtd_pkg::CH_M_LOW) || (mb[1:0] == 2'd3)) begin
            mouse_ev.action = vtd_pkg::ACT_UP;
         end else begin
            mouse_ev.action = vtd_pkg::ACT_DOWN;
         end
      end
   end

   always_comb begin
      ps_in         = ps_ff;
      sgr_in        = sgr_ff;
      esc_mods_in   = esc_mods_ff;
      ent           = '0;
      ent.esc_mods  = esc_mods_ff;
      do_clear      = 1'b0;
      do_digit      = 1'b0;
      do_semi       = 1'b0;
      if (accept) begin
         if (req_operation) begin
            ent.has_esc = (ps_ff == vtd_pkg::ST_ESC);
            ps_in       = vtd_pkg::ST_GROUND;
            sgr_in      = 1'b0;
            do_clear    = 1'b1;
         end else begin
            unique case (ps_ff)
               vtd_pkg::ST_GROUND: begin
                  if (req_in_char == vtd_pkg::CH_ESC) begin
                     ps_in       = vtd_pkg::ST_ESC;
                     esc_mods_in = req_in_mods;
                  end else begin
                     ent.has_event = 1'b1;
                     ent.ev        = char_ev;
                  end
               end
               vtd_pkg::ST_ESC: begin
                  if (req_in_char == vtd_pkg::CH_LBRACK) begin
                     ps_in    = vtd_pkg::ST_CSI;
                     sgr_in   = 1'b0;
                     do_clear = 1'b1;
                  end else if (req_in_char == vtd_pkg::CH_SS3_O) begin
                     ps_in = vtd_pkg::ST_SS3;
                  end else begin
                     ent.has_esc = 1'b1;
                     if (req_in_char == vtd_pkg::CH_ESC) begin
                        ps_in       = vtd_pkg::ST_ESC;
                        esc_mods_in = req_in_mods;
                     end else begin
                        ps_in         = vtd_pkg::ST_GROUND;
                        ent.has_event = 1'b1;
                        ent.ev        = char_ev;
                     end
                  end
               end
               vtd_pkg::ST_SS3: begin
                  ent.has_event = letter_hit.hit;
                  ent.ev        = vtd_pkg::build_key_ev(letter_hit.key, '0);
                  ps_in         = vtd_pkg::ST_GROUND;
               end
               vtd_pkg::ST_CSI: begin
                  if (sgr_ff) begin
                     if ((req_in_char == vtd_pkg::CH_M_UP) ||
                         (req_in_char == vtd_pkg::CH_M_LOW)) begin
                        ent.has_event = mouse_ok;
                        ent.ev        = mouse_ev;
                        ps_in         = vtd_pkg::ST_GROUND;
                        sgr_in        = 1'b0;
                        do_clear      = 1'b1;
                     end else if (is_digit) begin
                        do_digit = 1'b1;
                     end else if (req_in_char == vtd_pkg::CH_SEMI) begin
                        do_semi = 1'b1;
                     end else begin
                        ps_in    = vtd_pkg::ST_GROUND;
                        sgr_in   = 1'b0;
                        do_clear = 1'b1;
                     end
                  end else if (req_in_char == vtd_pkg::CH_LESS) begin
                     sgr_in   = 1'b1;
                     do_clear = 1'b1;
                  end else if (req_in_char == vtd_pkg::CH_TILDE) begin
                     ent.has_event = tilde_hit.hit;
                     ent.ev        = vtd_pkg::build_key_ev(tilde_hit.key, '0);
                     ps_in         = vtd_pkg::ST_GROUND;
                     sgr_in        = 1'b0;
                     do_clear      = 1'b1;
                  end else if (is_digit) begin
                     do_digit = 1'b1;
                  end else if (req_in_char == vtd_pkg::CH_SEMI) begin
                     do_semi = 1'b1;
                  end else begin
                     ent.has_event = letter_hit.hit;
                     ent.ev        = vtd_pkg::build_key_ev(letter_hit.key, '0);
                     ps_in         = vtd_pkg::ST_GROUND;
                     sgr_in        = 1'b0;
                     do_clear      = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Parameter accumulation.
   always_comb begin
      tilde_in      = tilde_ff;
      tilde_done_in = tilde_done_ff;
      fc_in         = fc_ff;
      fv_in         = fv_ff;
      cur_in        = cur_ff;
      if (do_clear) begin
         tilde_in      = '0;
         tilde_done_in = 1'b0;
         fc_in         = 2'd0;
         fv_in[0]      = '0;
         fv_in[1]      = '0;
         fv_in[2]      = '0;
         cur_in        = '0;
      end else if (do_digit) begin
         if (!tilde_done_ff) begin
            tilde_in = vtd_pkg::add_digit(tilde_ff, req_in_char[3:0]);
         end
         cur_in = vtd_pkg::add_digit(cur_ff, req_in_char[3:0]);
      end else if (do_semi) begin
         tilde_done_in = 1'b1;
         if (fc_ff != 2'd3) begin
            fv_in[fc_ff] = cur_ff;
            fc_in        = fc_ff + 2'd1;
         end
         cur_in = '0;
      end
   end

   assign q_push  = accept && (ent.has_esc || ent.has_event);
   assign q_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff         <= vtd_pkg::ST_GROUND;
         sgr_ff        <= 1'b0;
         esc_mods_ff   <= '0;
         tilde_ff      <= '0;
         tilde_done_ff <= 1'b0;
         fc_ff         <= 2'd0;
         fv_ff[0]      <= '0;
         fv_ff[1]      <= '0;
         fv_ff[2]      <= '0;
         cur_ff        <= '0;
      end else begin
         ps_ff         <= ps_in;
         sgr_ff        <= sgr_in;
         esc_mods_ff   <= esc_mods_in;
         tilde_ff      <= tilde_in;
         tilde_done_ff <= tilde_done_in;
         fc_ff         <= fc_in;
         fv_ff         <= fv_in;
         cur_ff        <= cur_in;
      end
   end

endmodule

// ===== rtl/vtd_queue.sv =====
// Small flip-flop queue of decoded entries between the parser and the result stage.
module vtd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  vtd_pkg::entry_type        push_entry,
   input  logic                      pop,
   output vtd_pkg::entry_type        head,
   output vtd_pkg::queue_status_type status
);

   vtd_pkg::entry_type                 mem_ff [vtd_pkg::QUEUE_DEPTH];
   logic [vtd_pkg::QPTR_WIDTH-1:0]     wptr_ff, wptr_in;
   logic [vtd_pkg::QPTR_WIDTH-1:0]     rptr_ff, rptr_in;
   logic [vtd_pkg::QPTR_WIDTH:0]       count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (vtd_pkg::QPTR_WIDTH + 1)'(vtd_pkg::QUEUE_DEPTH));
   assign head         = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff + (vtd_pkg::QPTR_WIDTH)'(push);
      rptr_in  = rptr_ff + (vtd_pkg::QPTR_WIDTH)'(pop);
      count_in = count_ff + (vtd_pkg::QPTR_WIDTH + 1)'(push) - (vtd_pkg::QPTR_WIDTH + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("queue pushed while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("queue popped while empty");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (vtd_pkg::QPTR_WIDTH + 1)'(vtd_pkg::QUEUE_DEPTH))
      else $error("queue count above its depth");

endmodule

// ===== rtl/vtd_back.sv =====
// Result stage: expands queue entries into one or two registered result items.
module vtd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  vtd_pkg::entry_type        head,
   input  vtd_pkg::queue_status_type q_status,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output vtd_pkg::event_type        rsp_event,
   output logic                      rsp_last
);

   logic               valid_ff, valid_in;
   logic               done_ff, done_in;
   vtd_pkg::event_type ev_ff, ev_in;
   logic               last_ff, last_in;
   logic               load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      q_pop    = 1'b0;
      valid_in = valid_ff && !rsp_ready;
      done_in  = done_ff;
      ev_in    = ev_ff;
      last_in  = last_ff;
      if (load && !q_status.empty) begin
         valid_in = 1'b1;
         if (head.has_esc && !done_ff) begin
            // Pending escape key goes first; its entry stays if an event follows.
            ev_in   = vtd_pkg::build_key_ev(vtd_pkg::KEY_ESC, head.esc_mods);
            last_in = !head.has_event;
            if (head.has_event) begin
               done_in = 1'b1;
            end else begin
               q_pop = 1'b1;
            end
         end else begin
            ev_in   = head.ev;
            last_in = 1'b1;
            done_in = 1'b0;
            q_pop   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff   <= ev_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_event = ev_ff;
   assign rsp_last  = last_ff;

   a_done_has_head: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!q_status.empty && head.has_esc && head.has_event))
      else $error("escape marked sent without a two-result entry at the head");

   a_not_last_means_done: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> done_ff)
      else $error("non-final result shown without its follow-up pending");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> (valid_ff && $stable(ev_ff) && $stable(last_ff)))
      else $error("result changed while waiting for the receiver");

endmodule

// ===== rtl/vt_escape_input_decoder_unit.sv =====
// Top level of the VT escape input decoder: parser, event queue and result stage.
//
// Usage: each request on the req_ channel is either a character (req_operation 0)
// with its code point and modifier bits, or a flush tick (req_operation 1) sent
// when the input goes idle. Decoded character, key and SGR mouse events leave on
// the rsp_ channel, one field per port; rsp_last marks the final result caused by
// a request. A request causes zero, one or two results; two only when a pending
// escape is released by an ordinary character.
// The parser writes the queue when it accepts a request, and the result register
// then loads from the queue when it is free, so rsp_valid comes from a register.
// Throughput: one request per cycle while the queue has room; the parser state
// update is a registered loop. The result register drains one item per cycle
// while rsp_ready is high; the four-entry queue absorbs the extra result items.
// Reset puts the parser in the ground state, clears all parameters and empties
// the queue and the result register. When the receiver stalls, the result holds
// and the parser keeps taking requests until the queue fills; req_ready then
// drops until the back end makes room.
module vt_escape_input_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [20:0] req_in_char,
   input  logic [2:0]  req_in_mods,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [3:0]  rsp_key_code,
   output logic [20:0] rsp_out_char,
   output logic [2:0]  rsp_out_mods,
   output logic [2:0]  rsp_mouse_button,
   output logic [1:0]  rsp_mouse_action,
   output logic [15:0] rsp_column,
   output logic [15:0] rsp_row,
   output logic        rsp_last
);

   // Queue handshake between the front and back parts.
   vtd_pkg::queue_status_type q_status;
   vtd_pkg::entry_type        q_entry;
   vtd_pkg::entry_type        q_head;
   logic                      q_push;
   logic                      q_pop;
   vtd_pkg::event_type        rsp_event;

   // The front end classifies every accepted request and queues what it produces.
   vtd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_in_char   (req_in_char),
      .req_in_mods   (req_in_mods),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   vtd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // The back end turns each entry into result items through the output register.
   vtd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_event (rsp_event),
      .rsp_last  (rsp_last)
   );

   assign rsp_event_kind   = rsp_event.kind;
   assign rsp_key_code     = rsp_event.key;
   assign rsp_out_char     = rsp_event.chr;
   assign rsp_out_mods     = rsp_event.mods;
   assign rsp_mouse_button = rsp_event.button;
   assign rsp_mouse_action = rsp_event.action;
   assign rsp_column       = rsp_event.column;
   assign rsp_row          = rsp_event.row;

endmodule
